// File: rtl/core/kbp_pkg.sv
// Shared types and constants for the keyboard backlight policy block.
package kbp_pkg;

   localparam int unsigned LEVEL_W    = 16;
   localparam int unsigned PCT_W      = 14;
   localparam int unsigned TIMER_W    = 13;
   localparam int unsigned STYLE_W    = 2;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned PROD_W     = LEVEL_W + PCT_W;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // level = (max_level * p + 5000) / 10000, done as (x >> 4) / 625 by a
   // reciprocal multiply; exact for every x below 2^30.
   localparam int unsigned DIV_PRE     = 4;
   localparam int unsigned SCALED_W    = PROD_W - DIV_PRE;
   localparam int unsigned RECIP_W     = 27;
   localparam int unsigned RECIP_SHIFT = 36;
   localparam int unsigned RPROD_W     = SCALED_W + RECIP_W;

   localparam logic [PCT_W-1:0]   PCT_FULL   = 14'd10000;
   localparam logic [RECIP_W-1:0] RECIP_625  = 27'd109951163;
   localparam logic [PROD_W-1:0]  ROUND_HALF = 30'd5000;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

   localparam logic [STYLE_W-1:0] STYLE_INSTANT = 2'd0;
   localparam logic [STYLE_W-1:0] STYLE_FAST    = 2'd1;
   localparam logic [STYLE_W-1:0] STYLE_SLOW    = 2'd2;
   localparam logic               CAUSE_AUTO    = 1'b0;
   localparam logic               CAUSE_USER    = 1'b1;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_VIDEO    = 3'd1,
      CMD_DIM      = 3'd2,
      CMD_OFF      = 3'd3,
      CMD_SHUTDOWN = 3'd4,
      CMD_INCREASE = 3'd5,
      CMD_DECREASE = 3'd6,
      CMD_AMBIENT  = 3'd7
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_LEVEL  = 3'd0,
      CSR_USER_MIN   = 3'd1,
      CSR_USER_DIM   = 3'd2,
      CSR_USER_MAX   = 3'd3,
      CSR_ALS_MIN    = 3'd4,
      CSR_ALS_DIM    = 3'd5,
      CSR_IGNORE_ALS = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      MUL_CUR   = 3'd0,
      MUL_CAP   = 3'd1,
      MUL_STEP0 = 3'd2,
      MUL_STEP1 = 3'd3,
      MUL_STEP2 = 3'd4,
      MUL_LEVEL = 3'd5
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        event_exec;
      logic        cur_ld;
      logic        cap_ld;
      logic        cmp;
      logic [1:0]  cmp_idx;
      logic        step_commit;
      logic        user_step;
      logic        pick;
      logic        div_init;
      logic        div_step;
      logic        finish;
      logic        publish;
      mul_sel_type mul_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic user_cmd;
      logic step_valid;
      logic apply;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/core/kbp_req_if.sv
// Input item channel: valid/ready handshake with event payload.
interface kbp_req_if import kbp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [2:0]             command;
   logic                   flag;
   logic [PCT_W-1:0]       ambient_percent;

   modport source (output valid, command, flag, ambient_percent, input ready);
   modport sink   (input valid, command, flag, ambient_percent, output ready);
endinterface

// File: rtl/core/kbp_rsp_if.sv
// Result item channel: valid/ready handshake with level report payload.
interface kbp_rsp_if import kbp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   level_changed;
   logic [LEVEL_W-1:0]     new_level;
   logic [PCT_W-1:0]       applied_percent;
   logic [STYLE_W-1:0]     transition_style;
   logic                   change_cause;
   logic [COUNT_W-1:0]     user_adjust_count;
   logic [COUNT_W-1:0]     als_adjust_count;

   modport source (output valid, level_changed, new_level, applied_percent,
                   transition_style, change_cause, user_adjust_count,
                   als_adjust_count, input ready);
   modport sink   (input valid, level_changed, new_level, applied_percent,
                   transition_style, change_cause, user_adjust_count,
                   als_adjust_count, output ready);
endinterface

// File: rtl/core/keyboard_backlight_policy_top.sv
// Top level of the keyboard backlight policy block.
// Each item runs the event step; an applied level adds the level multiply and
// reciprocal divide, a user step adds the step update, and the first user step
// adds the nearest-step search before it. One item at a time: the next is taken
// only once the result is registered, and a result stall holds it off. Reset
// (synchronous, active high) restores register defaults and the policy state.
module keyboard_backlight_policy_top import kbp_pkg::*; #(
   parameter int VIDEO_TIMEOUT_TICKS = 7000
) (
   input  logic                  clock,
   input  logic                  reset,
   kbp_req_if.sink               req_ch,
   kbp_rsp_if.source             rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller takes an item only when idle; the datapath latches the
   // payload on the load command, so the port fields go straight across.
   kbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kbp_datapath #(
      .VIDEO_TIMEOUT_TICKS (VIDEO_TIMEOUT_TICKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .item_command     (req_ch.command),
      .item_flag        (req_ch.flag),
      .item_ambient     (req_ch.ambient_percent),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_ch           (rsp_ch)
   );

endmodule

// File: rtl/core/kbp_ctrl.sv
// Sequencer for the backlight policy: event, step search, level divide, report.
module kbp_ctrl import kbp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_EVENT = 14'b00000000000010,
      S_SCUR  = 14'b00000000000100,
      S_SCAP  = 14'b00000000001000,
      S_S0    = 14'b00000000010000,
      S_S1    = 14'b00000000100000,
      S_S2    = 14'b00000001000000,
      S_SEND  = 14'b00000010000000,
      S_USTEP = 14'b00000100000000,
      S_PICK  = 14'b00001000000000,
      S_MULW  = 14'b00010000000000,
      S_DIV   = 14'b00100000000000,
      S_FIN   = 14'b01000000000000,
      S_DONE  = 14'b10000000000000
   } state_type;

   state_type              state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
      end else begin
         state_ff   <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mul_sel = MUL_LEVEL;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVENT;
            end
         end
         S_EVENT: begin
            cmd.event_exec = 1'b1;
            if (!status.user_cmd)       state_in = S_PICK;
            else if (status.step_valid) state_in = S_USTEP;
            else                        state_in = S_SCUR;
         end
         S_SCUR: begin
            cmd.mul_sel = MUL_CUR;
            state_in    = S_SCAP;
         end
         S_SCAP: begin
            cmd.cur_ld  = 1'b1;
            cmd.mul_sel = MUL_CAP;
            state_in    = S_S0;
         end
         S_S0: begin
            cmd.cap_ld  = 1'b1;
            cmd.mul_sel = MUL_STEP0;
            state_in    = S_S1;
         end
         S_S1: begin
            cmd.cmp     = 1'b1;
            cmd.cmp_idx = 2'd0;
            cmd.mul_sel = MUL_STEP1;
            state_in    = S_S2;
         end
         S_S2: begin
            cmd.cmp     = 1'b1;
            cmd.cmp_idx = 2'd1;
            cmd.mul_sel = MUL_STEP2;
            state_in    = S_SEND;
         end
         S_SEND: begin
            cmd.cmp         = 1'b1;
            cmd.cmp_idx     = 2'd2;
            cmd.step_commit = 1'b1;
            state_in        = S_USTEP;
         end
         S_USTEP: begin
            cmd.user_step = 1'b1;
            state_in      = S_PICK;
         end
         S_PICK: begin
            cmd.pick    = 1'b1;
            cmd.mul_sel = MUL_LEVEL;
            state_in    = status.apply ? S_MULW : S_DONE;
         end
         S_MULW: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: rtl/core/kbp_datapath.sv
// Policy state, configuration, shared multiplier, level divider and result register.
module kbp_datapath import kbp_pkg::*; #(
   parameter int VIDEO_TIMEOUT_TICKS = 7000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            item_command,
   input  logic                  item_flag,
   input  logic [PCT_W-1:0]      item_ambient,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   kbp_rsp_if.source             rsp_ch
);

   localparam logic [TIMER_W-1:0] TIMEOUT = TIMER_W'(VIDEO_TIMEOUT_TICKS);

   // configuration
   logic [LEVEL_W-1:0] max_level_ff;
   logic [PCT_W-1:0]   user_min_ff, user_dim_ff, user_max_ff, als_min_ff, als_dim_ff;
   logic               ignore_als_ff;

   // policy state
   logic               dimmed_ff, off_ff, shutdown_ff, video_ff, step_valid_ff;
   logic [TIMER_W-1:0] timer_ff;
   logic [1:0]         step_idx_ff;
   logic [PCT_W-1:0]   ambient_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [COUNT_W-1:0] user_cnt_ff, als_cnt_ff;

   // per item
   command_type        cmd_ff;
   logic               flag_ff;
   logic [PCT_W-1:0]   amb_ff;
   logic               eval_ff, full_ff, req_cause_ff;
   logic [STYLE_W-1:0] req_style_ff;
   logic               changed_ff, res_cause_ff, use_cause_ff;
   logic [PCT_W-1:0]   res_pct_ff, p_ff;
   logic [STYLE_W-1:0] res_style_ff, use_style_ff;

   // step search and divide
   logic [PROD_W-1:0]  prod_ff, cur_ff;
   logic [PROD_W:0]    best_ff;
   logic [1:0]         cand_ff;
   logic [SCALED_W-1:0] scaled_ff;
   logic [RPROD_W-1:0]  recip_prod_ff;

   // result register
   logic               out_valid_ff;
   logic               o_changed_ff, o_cause_ff;
   logic [LEVEL_W-1:0] o_level_ff;
   logic [PCT_W-1:0]   o_pct_ff;
   logic [STYLE_W-1:0] o_style_ff;
   logic [COUNT_W-1:0] o_user_ff, o_als_ff;

   logic               any_mode;
   logic [PCT_W-1:0]   step_val, undimmed, dim_pick, dim_val, p_sel, p_clamp, mul_b;
   logic [STYLE_W-1:0] style_sel;
   logic               cause_sel;
   logic [LEVEL_W-1:0] mul_a, lvl_clamp, level_calc;
   logic [PROD_W-1:0]  step_gap, div_sum;
   logic               new_best;

   assign any_mode = shutdown_ff | video_ff | off_ff | dimmed_ff;

   always_comb begin
      case (step_idx_ff)
         2'd0:    step_val = user_min_ff;
         2'd1:    step_val = user_dim_ff;
         default: step_val = user_max_ff;
      endcase
   end

   assign undimmed = step_valid_ff ? step_val : ambient_ff;
   assign dim_pick = step_valid_ff ? user_dim_ff : als_dim_ff;
   assign dim_val  = (dim_pick < undimmed) ? dim_pick : undimmed;

   // priority pick of the target percent
   always_comb begin
      p_sel     = undimmed;
      style_sel = STYLE_SLOW;
      cause_sel = CAUSE_AUTO;
      if (!full_ff) begin
         style_sel = req_style_ff;
         cause_sel = req_cause_ff;
      end else if (shutdown_ff) begin
         p_sel     = '0;
         style_sel = STYLE_INSTANT;
      end else if (video_ff || off_ff) begin
         p_sel = step_valid_ff ? user_min_ff : als_min_ff;
      end else if (dimmed_ff) begin
         p_sel = dim_val;
      end
   end

   assign p_clamp = (p_sel > PCT_FULL) ? PCT_FULL : p_sel;

   assign status.user_cmd   = (cmd_ff == CMD_INCREASE) || (cmd_ff == CMD_DECREASE);
   assign status.step_valid = step_valid_ff;
   assign status.apply      = eval_ff && (max_level_ff != '0) && (full_ff || !any_mode);
   assign status.out_free   = !out_valid_ff || rsp_ch.ready;

   // shared multiplier operands
   assign lvl_clamp = (level_ff < max_level_ff) ? level_ff : max_level_ff;
   always_comb begin
      mul_a = max_level_ff;
      case (cmd.mul_sel)
         MUL_CUR: begin
            mul_a = lvl_clamp;
            mul_b = PCT_FULL;
         end
         MUL_CAP:   mul_b = user_max_ff;
         MUL_STEP0: mul_b = user_min_ff;
         MUL_STEP1: mul_b = user_dim_ff;
         MUL_STEP2: mul_b = user_max_ff;
         MUL_LEVEL: mul_b = p_clamp;
         default:   mul_b = p_clamp;
      endcase
   end

   assign step_gap   = (cur_ff > prod_ff) ? (cur_ff - prod_ff) : (prod_ff - cur_ff);
   assign new_best   = {1'b0, step_gap} < best_ff;
   assign div_sum    = prod_ff + ROUND_HALF;
   assign level_calc = recip_prod_ff[RECIP_SHIFT +: LEVEL_W];

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.load) begin
         cmd_ff  <= command_type'(item_command);
         flag_ff <= item_flag;
         amb_ff  <= item_ambient;
      end
      if (cmd.cur_ld) cur_ff <= prod_ff;
      if (cmd.cap_ld) begin
         if (prod_ff < cur_ff) cur_ff <= prod_ff;
         best_ff <= {prod_ff, 1'b0};
         cand_ff <= 2'd0;
      end
      if (cmd.cmp && new_best) begin
         best_ff <= {1'b0, step_gap};
         cand_ff <= cmd.cmp_idx;
      end
      if (cmd.pick) begin
         p_ff         <= p_clamp;
         use_style_ff <= style_sel;
         use_cause_ff <= cause_sel;
      end
      // divide by 10000: drop the factor 16, then multiply by 2^36/625
      if (cmd.div_init) scaled_ff <= div_sum[PROD_W-1:DIV_PRE];
      if (cmd.div_step) recip_prod_ff <= scaled_ff * RECIP_625;
      if (cmd.publish) begin
         o_changed_ff <= changed_ff;
         o_level_ff   <= level_ff;
         o_pct_ff     <= res_pct_ff;
         o_style_ff   <= res_style_ff;
         o_cause_ff   <= res_cause_ff;
         o_user_ff    <= user_cnt_ff;
         o_als_ff     <= als_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff  <= 16'd100;
         user_min_ff   <= '0;
         user_dim_ff   <= 14'd1000;
         user_max_ff   <= PCT_FULL;
         als_min_ff    <= '0;
         als_dim_ff    <= 14'd1000;
         ignore_als_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_LEVEL:  max_level_ff  <= csr_write_data;
            CSR_USER_MIN:   user_min_ff   <= csr_write_data[PCT_W-1:0];
            CSR_USER_DIM:   user_dim_ff   <= csr_write_data[PCT_W-1:0];
            CSR_USER_MAX:   user_max_ff   <= csr_write_data[PCT_W-1:0];
            CSR_ALS_MIN:    als_min_ff    <= csr_write_data[PCT_W-1:0];
            CSR_ALS_DIM:    als_dim_ff    <= csr_write_data[PCT_W-1:0];
            CSR_IGNORE_ALS: ignore_als_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dimmed_ff     <= 1'b0;
         off_ff        <= 1'b0;
         shutdown_ff   <= 1'b0;
         video_ff      <= 1'b0;
         timer_ff      <= '0;
         step_valid_ff <= 1'b0;
         step_idx_ff   <= 2'd0;
         ambient_ff    <= PCT_FULL;
         level_ff      <= '0;
         user_cnt_ff   <= '0;
         als_cnt_ff    <= '0;
         eval_ff       <= 1'b0;
         full_ff       <= 1'b1;
         req_style_ff  <= STYLE_SLOW;
         req_cause_ff  <= CAUSE_AUTO;
         changed_ff    <= 1'b0;
         res_pct_ff    <= '0;
         res_style_ff  <= STYLE_INSTANT;
         res_cause_ff  <= CAUSE_AUTO;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            eval_ff      <= 1'b0;
            full_ff      <= 1'b1;
            changed_ff   <= 1'b0;
            res_pct_ff   <= '0;
            res_style_ff <= STYLE_INSTANT;
            res_cause_ff <= CAUSE_AUTO;
         end
         if (cmd.event_exec) begin
            case (cmd_ff)
               CMD_TICK: begin
                  if (timer_ff != '0) begin
                     timer_ff <= timer_ff - 1'b1;
                     if (timer_ff == TIMER_W'(1)) begin
                        video_ff <= 1'b0;
                        eval_ff  <= 1'b1;
                     end
                  end
               end
               CMD_VIDEO: begin
                  if (flag_ff != video_ff) begin
                     video_ff <= flag_ff;
                     eval_ff  <= 1'b1;
                  end
                  timer_ff <= flag_ff ? TIMEOUT : '0;
               end
               CMD_DIM: begin
                  if (flag_ff != dimmed_ff) begin
                     dimmed_ff <= flag_ff;
                     eval_ff   <= 1'b1;
                  end
               end
               CMD_OFF: begin
                  if (flag_ff != off_ff) begin
                     off_ff  <= flag_ff;
                     eval_ff <= 1'b1;
                  end
               end
               CMD_SHUTDOWN: begin
                  if (flag_ff != shutdown_ff) begin
                     shutdown_ff <= flag_ff;
                     eval_ff     <= 1'b1;
                  end
               end
               CMD_AMBIENT: begin
                  if (!ignore_als_ff) begin
                     ambient_ff   <= amb_ff;
                     if (als_cnt_ff != COUNT_MAX) als_cnt_ff <= als_cnt_ff + 1'b1;
                     eval_ff      <= 1'b1;
                     full_ff      <= 1'b0;
                     req_style_ff <= STYLE_SLOW;
                     req_cause_ff <= CAUSE_AUTO;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.step_commit) begin
            step_idx_ff   <= new_best ? cmd.cmp_idx : cand_ff;
            step_valid_ff <= 1'b1;
         end
         if (cmd.user_step) begin
            if (cmd_ff == CMD_INCREASE) begin
               if ((!flag_ff || step_idx_ff == 2'd0) && step_idx_ff < 2'd2)
                  step_idx_ff <= step_idx_ff + 1'b1;
            end else if (step_idx_ff > (flag_ff ? 2'd0 : 2'd1)) begin
               step_idx_ff <= step_idx_ff - 1'b1;
            end
            if (user_cnt_ff != COUNT_MAX) user_cnt_ff <= user_cnt_ff + 1'b1;
            eval_ff      <= 1'b1;
            full_ff      <= 1'b0;
            req_style_ff <= STYLE_FAST;
            req_cause_ff <= CAUSE_USER;
         end
         if (cmd.finish && level_calc != level_ff) begin
            level_ff     <= level_calc;
            changed_ff   <= 1'b1;
            res_pct_ff   <= p_ff;
            res_style_ff <= use_style_ff;
            res_cause_ff <= use_cause_ff;
         end
         if (cmd.publish)          out_valid_ff <= 1'b1;
         else if (rsp_ch.ready)    out_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.level_changed     = o_changed_ff;
   assign rsp_ch.new_level         = o_level_ff;
   assign rsp_ch.applied_percent   = o_pct_ff;
   assign rsp_ch.transition_style  = o_style_ff;
   assign rsp_ch.change_cause      = o_cause_ff;
   assign rsp_ch.user_adjust_count = o_user_ff;
   assign rsp_ch.als_adjust_count  = o_als_ff;

endmodule

// File: rtl/core/kbp_checker.sv
// Port-level checks for the keyboard backlight policy block and their binding.
module kbp_checker import kbp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               level_changed,
   input logic [LEVEL_W-1:0] new_level,
   input logic [PCT_W-1:0]   applied_percent,
   input logic [STYLE_W-1:0] transition_style,
   input logic               change_cause
);

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item taken while another is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(new_level))
      else $error("result level moved while stalled");

   a_no_change_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !level_changed) |->
         (applied_percent == '0 && transition_style == STYLE_INSTANT &&
          change_cause == CAUSE_AUTO))
      else $error("report fields set without a level change");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (applied_percent <= PCT_FULL && transition_style != 2'd3))
      else $error("reported percent or style out of range");

endmodule

bind keyboard_backlight_policy_top kbp_checker u_kbp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .level_changed    (rsp_ch.level_changed),
   .new_level        (rsp_ch.new_level),
   .applied_percent  (rsp_ch.applied_percent),
   .transition_style (rsp_ch.transition_style),
   .change_cause     (rsp_ch.change_cause)
);

// File: bench/kbp_bench_pkg.sv
`timescale 1ns / 1ps
// Bench-side item types for the keyboard backlight policy testbench.
package kbp_bench_pkg;
   import kbp_pkg::*;

   typedef struct {
      command_type      command;
      logic             flag;
      logic [PCT_W-1:0] ambient_percent;
   } event_item_t;

   typedef struct {
      logic               level_changed;
      logic [LEVEL_W-1:0] new_level;
      logic [PCT_W-1:0]   applied_percent;
      logic [STYLE_W-1:0] transition_style;
      logic               change_cause;
      logic [COUNT_W-1:0] user_adjust_count;
      logic [COUNT_W-1:0] als_adjust_count;
   } level_report_t;
endpackage

// File: bench/keyboard_backlight_policy_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the keyboard backlight policy top level.
module keyboard_backlight_policy_top_tb;
   import kbp_pkg::*;
   import kbp_bench_pkg::*;

   localparam int VIDEO_TICKS = 7000;
   localparam int STALL_LIMIT = 20000;
   localparam int LONG_HOLD   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   kbp_req_if req_ch ();
   kbp_rsp_if rsp_ch ();

   keyboard_backlight_policy_top #(.VIDEO_TIMEOUT_TICKS(VIDEO_TICKS)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---- predictor state (mirror of the block) ----
   int unsigned cfg_max_level, cfg_user_min, cfg_user_dim, cfg_user_max;
   int unsigned cfg_als_min, cfg_als_dim, cfg_ignore_als;
   bit          dimmed_on, off_on, shutdown_on, video_on, step_chosen;
   int unsigned video_left, step_sel, ambient_pct, level_now, user_adj, als_adj;
   level_report_t rep;

   event_item_t   pending_items[$];
   level_report_t expected_reports[$];
   int            fail_count = 0;
   bit            hold_sink = 1'b0;   // long receiver hold-off request
   bit            hold_source = 1'b0; // sender pause request

   function automatic int unsigned step_pct(int unsigned i);
      if (i == 0) return cfg_user_min;
      if (i == 1) return cfg_user_dim;
      return cfg_user_max;
   endfunction

   function automatic int unsigned undimmed_pct();
      return step_chosen ? step_pct(step_sel) : ambient_pct;
   endfunction

   // Percent to level with round half up; report only on a real change.
   function automatic void apply_pct(int unsigned p, int unsigned style, bit cause);
      longint unsigned lvl;
      if (cfg_max_level == 0) return;
      if (p > 10000) p = 10000;
      lvl = (longint'(cfg_max_level) * p * 2 + 10000) / 20000;
      if (lvl == level_now) return;
      level_now = lvl & 16'hFFFF;
      rep.level_changed = 1'b1;
      rep.applied_percent = p;
      rep.transition_style = style;
      rep.change_cause = cause;
   endfunction

   function automatic void reevaluate();
      int unsigned p, u;
      if (shutdown_on) apply_pct(0, STYLE_INSTANT, CAUSE_AUTO);
      else if (video_on || off_on)
         apply_pct(step_chosen ? cfg_user_min : cfg_als_min, STYLE_SLOW, CAUSE_AUTO);
      else if (dimmed_on) begin
         p = step_chosen ? cfg_user_dim : cfg_als_dim;
         u = undimmed_pct();
         apply_pct(p < u ? p : u, STYLE_SLOW, CAUSE_AUTO);
      end else apply_pct(undimmed_pct(), STYLE_SLOW, CAUSE_AUTO);
   endfunction

   function automatic void apply_undimmed(int unsigned style, bit cause);
      if (shutdown_on || video_on || off_on || dimmed_on) return;
      apply_pct(undimmed_pct(), style, cause);
   endfunction

   // Nearest step to the current level, first one wins ties.
   function automatic void choose_step();
      longint unsigned cur, cap, best, s, d;
      int unsigned idx;
      if (step_chosen) return;
      idx = 0;
      cur = (level_now < cfg_max_level ? level_now : cfg_max_level) * 64'd10000;
      cap = longint'(cfg_user_max) * cfg_max_level;
      if (cur > cap) cur = cap;
      best = 2 * cap;
      for (int i = 0; i < 3; i++) begin
         s = longint'(step_pct(i)) * cfg_max_level;
         d = cur > s ? cur - s : s - cur;
         if (d < best) begin
            best = d;
            idx = i;
         end
      end
      step_sel = idx;
      step_chosen = 1'b1;
   endfunction

   function automatic void update_mode(ref bit f, input bit v);
      if (f == v) return;
      f = v;
      reevaluate();
   endfunction

   function automatic level_report_t predict_report(event_item_t it);
      rep = '{default: '0};
      case (it.command)
         CMD_TICK: if (video_left != 0) begin
            video_left--;
            if (video_left == 0) begin
               video_on = 1'b0;
               reevaluate();
            end
         end
         CMD_VIDEO: begin
            update_mode(video_on, it.flag);
            video_left = it.flag ? VIDEO_TICKS : 0;
         end
         CMD_DIM:      update_mode(dimmed_on, it.flag);
         CMD_OFF:      update_mode(off_on, it.flag);
         CMD_SHUTDOWN: update_mode(shutdown_on, it.flag);
         CMD_INCREASE: begin
            choose_step();
            if ((!it.flag || step_sel == 0) && step_sel < 2) step_sel++;
            if (user_adj < 16'hFFFF) user_adj++;
            apply_undimmed(STYLE_FAST, CAUSE_USER);
         end
         CMD_DECREASE: begin
            choose_step();
            if (step_sel > (it.flag ? 0 : 1)) step_sel--;
            if (user_adj < 16'hFFFF) user_adj++;
            apply_undimmed(STYLE_FAST, CAUSE_USER);
         end
         default: if (!cfg_ignore_als) begin
            ambient_pct = it.ambient_percent;
            if (als_adj < 16'hFFFF) als_adj++;
            apply_undimmed(STYLE_SLOW, CAUSE_AUTO);
         end
      endcase
      rep.new_level = level_now;
      rep.user_adjust_count = user_adj;
      rep.als_adjust_count = als_adj;
      return rep;
   endfunction

   function automatic int unsigned short_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // ---- driver: offers queued items, random gaps between them ----
   int unsigned drv_gap = 0;
   bit          drv_taken = 1'b0;   // offered item was accepted at the last edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !drv_taken) begin
         // hold the offered item until it is taken
      end else begin
         if (drv_taken) begin
            drv_taken = 1'b0;
            drv_gap = short_gap();
         end
         if (drv_gap > 0 || hold_source || pending_items.size() == 0) begin
            if (drv_gap > 0) drv_gap--;
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid <= 1'b1;
            req_ch.command <= pending_items[0].command;
            req_ch.flag <= pending_items[0].flag;
            req_ch.ambient_percent <= pending_items[0].ambient_percent;
         end
      end
   end

   // Accepted item: predict at the edge it is taken.
   always @(posedge clock) begin
      event_item_t it;
      if (!reset && req_ch.valid && req_ch.ready) begin
         it = pending_items.pop_front();
         expected_reports = {expected_reports, predict_report(it)};
         drv_taken = 1'b1;
      end
   end

   // ---- receiver: ready with random stalls, long hold-off on request ----
   int unsigned rcv_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_sink) begin
         hold_sink = 1'b0;
         rcv_gap = LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (rcv_gap > 0) begin
         rcv_gap--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rcv_gap = short_gap();
         rsp_ch.ready <= (rcv_gap == 0);
      end
   end

   // ---- monitor: compare each report with the oldest expectation ----
   always @(posedge clock) begin
      level_report_t e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_reports.size() == 0) begin
            $error("report with no expectation pending");
            fail_count++;
         end else begin
            e = expected_reports.pop_front();
            if (rsp_ch.level_changed !== e.level_changed) begin
               $error("level_changed exp %0d got %0d", e.level_changed, rsp_ch.level_changed);
               fail_count++;
            end
            if (rsp_ch.new_level !== e.new_level) begin
               $error("new_level exp %0d got %0d", e.new_level, rsp_ch.new_level);
               fail_count++;
            end
            if (rsp_ch.applied_percent !== e.applied_percent) begin
               $error("applied_percent exp %0d got %0d",
                      e.applied_percent, rsp_ch.applied_percent);
               fail_count++;
            end
            if (rsp_ch.transition_style !== e.transition_style) begin
               $error("transition_style exp %0d got %0d",
                      e.transition_style, rsp_ch.transition_style);
               fail_count++;
            end
            if (rsp_ch.change_cause !== e.change_cause) begin
               $error("change_cause exp %0d got %0d", e.change_cause, rsp_ch.change_cause);
               fail_count++;
            end
            if (rsp_ch.user_adjust_count !== e.user_adjust_count) begin
               $error("user_adjust_count exp %0d got %0d",
                      e.user_adjust_count, rsp_ch.user_adjust_count);
               fail_count++;
            end
            if (rsp_ch.als_adjust_count !== e.als_adjust_count) begin
               $error("als_adjust_count exp %0d got %0d",
                      e.als_adjust_count, rsp_ch.als_adjust_count);
               fail_count++;
            end
         end
      end
   end

   // ---- watchdog: cycles with no handshake on either side ----
   int unsigned idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else if (pending_items.size() != 0 || expected_reports.size() != 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // ---- stimulus helpers ----
   task automatic write_reg(csr_index_type idx, int unsigned val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= CSR_DATA_W'(val);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_MAX_LEVEL:  cfg_max_level = val & 16'hFFFF;
         CSR_USER_MIN:   cfg_user_min = val & 14'h3FFF;
         CSR_USER_DIM:   cfg_user_dim = val & 14'h3FFF;
         CSR_USER_MAX:   cfg_user_max = val & 14'h3FFF;
         CSR_ALS_MIN:    cfg_als_min = val & 14'h3FFF;
         CSR_ALS_DIM:    cfg_als_dim = val & 14'h3FFF;
         default:        cfg_ignore_als = val & 1;
      endcase
   endtask

   // Wait until every item is taken and every report is back, plus latency slack.
   task automatic drain();
      while (pending_items.size() != 0 || expected_reports.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic push_item(command_type c, bit f, int unsigned amb);
      event_item_t it;
      it.command = c;
      it.flag = f;
      it.ambient_percent = amb;
      pending_items = {pending_items, it};
   endtask

   function automatic int unsigned rand_pct();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 10000;
         2: return $urandom_range(10001, 16383); // above full scale, clamped
         default: return $urandom_range(0, 10000);
      endcase
   endfunction

   // Mostly well-formed mode sequences with random content, some noise.
   task automatic push_random(int unsigned n);
      int unsigned k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 25) push_item($urandom_range(0, 1) ? CMD_INCREASE : CMD_DECREASE,
                               $urandom_range(0, 1), $urandom_range(0, 16383));
         else if (k < 45) push_item(CMD_AMBIENT, $urandom_range(0, 1), rand_pct());
         else if (k < 65) push_item(command_type'($urandom_range(1, 4)),
                                    $urandom_range(0, 1), $urandom_range(0, 16383));
         else if (k < 70) begin
            // dim then wake, a typical inactivity pair
            push_item(CMD_DIM, 1'b1, 0);
            push_item(CMD_DIM, 1'b0, 0);
         end else push_item(CMD_TICK, $urandom_range(0, 1), $urandom_range(0, 16383));
      end
   endtask

   task automatic random_config();
      write_reg(CSR_MAX_LEVEL, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                               : $urandom_range(1, 255));
      write_reg(CSR_USER_MIN, rand_pct());
      write_reg(CSR_USER_DIM, rand_pct());
      write_reg(CSR_USER_MAX, rand_pct());
      write_reg(CSR_ALS_MIN, rand_pct());
      write_reg(CSR_ALS_DIM, rand_pct());
      write_reg(CSR_IGNORE_ALS, $urandom_range(0, 3) == 0);
   endtask

   initial begin
      cfg_max_level = 100; cfg_user_min = 0; cfg_user_dim = 1000;
      cfg_user_max = 10000; cfg_als_min = 0; cfg_als_dim = 1000; cfg_ignore_als = 0;
      dimmed_on = 0; off_on = 0; shutdown_on = 0; video_on = 0; step_chosen = 0;
      video_left = 0; step_sel = 0; ambient_pct = 10000; level_now = 0;
      user_adj = 0; als_adj = 0;
      req_ch.valid = 1'b0; req_ch.command = CMD_TICK; req_ch.flag = 1'b0;
      req_ch.ambient_percent = '0; rsp_ch.ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: all commands (tick set only), ambient extremes, step search.
      push_item(CMD_AMBIENT, 1'b0, 10000);
      push_item(CMD_AMBIENT, 1'b1, 16383);        // clamped above full scale
      push_item(CMD_INCREASE, 1'b1, 0);           // first step choice
      push_item(CMD_DECREASE, 1'b0, 0);
      push_item(CMD_DECREASE, 1'b1, 0);           // allow off
      push_item(CMD_INCREASE, 1'b0, 0);
      push_item(CMD_DIM, 1'b1, 0);
      push_item(CMD_DIM, 1'b1, 0);                // same flag, no effect
      push_item(CMD_OFF, 1'b1, 0);
      push_item(CMD_OFF, 1'b0, 0);
      push_item(CMD_DIM, 1'b0, 0);
      push_item(CMD_VIDEO, 1'b1, 0);
      push_item(CMD_TICK, 1'b1, 0);
      push_item(CMD_VIDEO, 1'b0, 0);
      push_item(CMD_SHUTDOWN, 1'b1, 0);
      push_item(CMD_INCREASE, 1'b0, 0);
      push_item(CMD_SHUTDOWN, 1'b0, 0);
      push_item(CMD_AMBIENT, 1'b0, 0);
      drain();

      // Video on, a burst of ticks short of the timeout, video off.
      push_item(CMD_VIDEO, 1'b1, 0);
      for (int i = 0; i < 50; i++) push_item(CMD_TICK, 1'b0, 0);
      push_item(CMD_VIDEO, 1'b0, 0);
      drain();

      // Zero max level and ignored ambient events.
      write_reg(CSR_MAX_LEVEL, 0);
      write_reg(CSR_IGNORE_ALS, 1);
      push_item(CMD_AMBIENT, 1'b0, 5000);
      push_item(CMD_INCREASE, 1'b0, 0);
      drain();
      write_reg(CSR_MAX_LEVEL, 65535);
      write_reg(CSR_IGNORE_ALS, 0);
      write_reg(CSR_USER_MAX, 0);
      push_random(40);
      drain();

      // Long receiver hold-off while the sender keeps offering items.
      hold_sink = 1'b1;
      push_random(30);
      drain();

      // Random phases across settings; mid-phase the sender pauses until
      // every outstanding report is back.
      for (int ph = 0; ph < 9; ph++) begin
         random_config();
         push_random(95);
         repeat (100) @(posedge clock);
         hold_source = 1'b1;
         while (expected_reports.size() != 0) @(posedge clock);
         repeat ($urandom_range(5, 50)) @(posedge clock);
         hold_source = 1'b0;
         push_random(95);
         drain();
      end
      drain();

      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

// File: sim.f
rtl/core/kbp_pkg.sv
rtl/core/kbp_req_if.sv
rtl/core/kbp_rsp_if.sv
rtl/core/kbp_ctrl.sv
rtl/core/kbp_datapath.sv
rtl/core/keyboard_backlight_policy_top.sv
rtl/core/kbp_checker.sv
bench/kbp_bench_pkg.sv
bench/keyboard_backlight_policy_top_tb.sv
